@@ rtl/core/gpr_pkg.sv @@
// ----------------------------------------------------------------------------
// gpr_pkg
// Shared types and codes of the RGB pyramid reduce block.
// ----------------------------------------------------------------------------
package gpr_pkg;

    typedef logic [2:0][7:0] rgb_t;           // [0] red, [1] green, [2] blue
    typedef logic [1:0][2:0][7:0] line_word_t; // [0] row r-2, [1] row r-1
    typedef logic [2:0][2:0][7:0] win_col_t;   // [0] row r-2 .. [2] row r

    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 12'd480;
    localparam logic [CFG_W-1:0] MIN_DIM            = 12'd3;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_COMPUTE = 2'd1;
    localparam logic [1:0] KIND_REPLAY  = 2'd2;
    localparam logic [1:0] KIND_REPEAT  = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic       row_end;
        logic       frame_end;
    } pix_ctrl_t;

endpackage

@@ rtl/core/gpr_ctrl.sv @@
// ----------------------------------------------------------------------------
// gpr_ctrl
// Configuration registers, raster counters and per-pixel output decision.
// ----------------------------------------------------------------------------
module gpr_ctrl #(
    parameter int MAX_WIDTH = 2048,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int OW = $clog2(MAX_WIDTH / 2)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [gpr_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [gpr_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                             accept,
    output logic [CW-1:0]                    col,
    output logic [OW-1:0]                    idx,
    output gpr_pkg::pix_ctrl_t               ctrl
);

    localparam int MW_BITS = $clog2(MAX_WIDTH + 1);
    localparam int EW = (MW_BITS > gpr_pkg::CFG_W) ? MW_BITS : gpr_pkg::CFG_W;

    logic [gpr_pkg::CFG_W-1:0] width_reg, width_next;
    logic [gpr_pkg::CFG_W-1:0] height_reg, height_next;
    logic [CW-1:0]             col_reg, col_next;
    logic [gpr_pkg::CFG_W-1:0] row_reg, row_next;

    logic [EW-1:0]             eff_w;
    logic [EW-1:0]             w_last;
    logic [gpr_pkg::CFG_W-1:0] eff_h;
    logic [gpr_pkg::CFG_W-1:0] h_last;
    logic [CW-1:0]             col_minus2;
    logic                      last_col;
    logic                      last_row;
    logic                      even_col;
    logic                      repeat_col;
    logic                      compute_row;
    logic                      replay_row;

    always_comb
    begin
        if (width_reg < gpr_pkg::MIN_DIM)
        begin
            eff_w = EW'(3);
        end
        else if (EW'(width_reg) > EW'(MAX_WIDTH))
        begin
            eff_w = EW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = EW'(width_reg);
        end
        w_last = eff_w - EW'(1);
        eff_h = (height_reg < gpr_pkg::MIN_DIM) ? gpr_pkg::MIN_DIM : height_reg;
        h_last = eff_h - gpr_pkg::CFG_W'(1);
    end

    assign last_col    = (EW'(col_reg) == w_last);
    assign last_row    = (row_reg == h_last);
    assign even_col    = (col_reg >= CW'(2)) && !col_reg[0];
    assign repeat_col  = last_col && !eff_w[0];
    assign compute_row = (row_reg >= gpr_pkg::CFG_W'(2)) && !row_reg[0];
    assign replay_row  = last_row && !eff_h[0];
    assign col_minus2  = col_reg - CW'(2);

    always_comb
    begin
        ctrl.kind = gpr_pkg::KIND_NONE;
        if (compute_row || replay_row)
        begin
            if (even_col)
            begin
                ctrl.kind = compute_row ? gpr_pkg::KIND_COMPUTE : gpr_pkg::KIND_REPLAY;
            end
            else if (repeat_col)
            begin
                ctrl.kind = gpr_pkg::KIND_REPEAT;
            end
        end
        ctrl.row_end   = last_col;
        ctrl.frame_end = last_col && last_row;
    end

    assign col = col_reg;
    assign idx = col_minus2[OW:1];

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                gpr_pkg::REG_FRAME_WIDTH:  width_next  = cfg_wdata;
                gpr_pkg::REG_FRAME_HEIGHT: height_next = cfg_wdata;
                default:                   width_next  = width_reg;
            endcase
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + gpr_pkg::CFG_W'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= gpr_pkg::FRAME_WIDTH_RESET;
            height_reg <= gpr_pkg::FRAME_HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> (col_reg == '0) && (row_reg == '0))
        else $error("Raster position not cleared after a register write.");

    a_col_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        EW'(col_reg) <= w_last)
        else $error("Column counter beyond the line width.");

    a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= h_last)
        else $error("Row counter beyond the frame height.");

endmodule

@@ rtl/core/gpr_line_buf.sv @@
// ----------------------------------------------------------------------------
// gpr_line_buf
// Two-line input buffer, 3x3 window and binomial filter of the three channels.
// ----------------------------------------------------------------------------
module gpr_line_buf #(
    parameter int MAX_WIDTH = 2048,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [CW-1:0] rd_addr,
    input  logic          adv,
    input  logic [CW-1:0] wr_addr,
    input  gpr_pkg::rgb_t cur_pix,
    output gpr_pkg::rgb_t filt_pix
);

    gpr_pkg::line_word_t line_mem [MAX_WIDTH];
    gpr_pkg::line_word_t rd_data_reg;

    gpr_pkg::win_col_t win1_reg;
    gpr_pkg::win_col_t win2_reg;
    gpr_pkg::win_col_t new_col;

    function automatic logic [7:0] filt_ch(
        input gpr_pkg::win_col_t a,
        input gpr_pkg::win_col_t b,
        input gpr_pkg::win_col_t c,
        input int                ch
    );
        logic [9:0]  va;
        logic [9:0]  vb;
        logic [9:0]  vc;
        logic [11:0] s;
        va = 10'(a[0][ch]) + {1'b0, a[1][ch], 1'b0} + 10'(a[2][ch]);
        vb = 10'(b[0][ch]) + {1'b0, b[1][ch], 1'b0} + 10'(b[2][ch]);
        vc = 10'(c[0][ch]) + {1'b0, c[1][ch], 1'b0} + 10'(c[2][ch]);
        s  = 12'(va) + {1'b0, vb, 1'b0} + 12'(vc) + 12'd8;
        return s[11:4];
    endfunction

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= line_mem[rd_addr];
        end
        if (adv)
        begin
            line_mem[wr_addr] <= {cur_pix, rd_data_reg[1]};
        end
    end

    assign new_col = {cur_pix, rd_data_reg[1], rd_data_reg[0]};

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            filt_pix[ch] = filt_ch(win1_reg, win2_reg, new_col, ch);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win1_reg <= '0;
            win2_reg <= '0;
        end
        else if (adv)
        begin
            win1_reg <= win2_reg;
            win2_reg <= new_col;
        end
    end

endmodule

@@ rtl/core/gpr_out_stage.sv @@
// ----------------------------------------------------------------------------
// gpr_out_stage
// Reduced-row store, result selection and the registered output channel.
// ----------------------------------------------------------------------------
module gpr_out_stage #(
    parameter int MAX_WIDTH = 2048,
    localparam int OW = $clog2(MAX_WIDTH / 2)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  gpr_pkg::pix_ctrl_t in_ctrl,
    input  logic [OW-1:0]      in_idx,
    input  gpr_pkg::rgb_t      in_pix,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata,
    output logic               m_tlast,
    output logic               m_tuser
);

    gpr_pkg::rgb_t row_mem [MAX_WIDTH / 2];
    gpr_pkg::rgb_t row_rd_reg;

    logic               s2_valid_reg, s2_valid_next;
    gpr_pkg::pix_ctrl_t s2_ctrl_reg;
    logic [OW-1:0]      s2_idx_reg;
    gpr_pkg::rgb_t      s2_pix_reg;
    gpr_pkg::rgb_t      last_pix_reg;
    gpr_pkg::rgb_t      pix_sel;

    logic               out_valid_reg, out_valid_next;
    gpr_pkg::rgb_t      out_pix_reg;
    logic               out_last_reg;
    logic               out_user_reg;

    logic               take;
    logic               s2_adv;

    assign s2_adv   = s2_valid_reg && (!out_valid_reg || m_tready);
    assign in_ready = !s2_valid_reg || s2_adv;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        case (s2_ctrl_reg.kind)
            gpr_pkg::KIND_REPLAY: pix_sel = row_rd_reg;
            gpr_pkg::KIND_REPEAT: pix_sel = last_pix_reg;
            default:              pix_sel = s2_pix_reg;
        endcase
    end

    always_comb
    begin
        if (take)
        begin
            s2_valid_next = (in_ctrl.kind != gpr_pkg::KIND_NONE);
        end
        else
        begin
            s2_valid_next = s2_valid_reg && !s2_adv;
        end
        if (s2_adv)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !m_tready;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && (in_ctrl.kind == gpr_pkg::KIND_REPLAY))
        begin
            row_rd_reg <= row_mem[in_idx];
        end
        if (s2_adv && (s2_ctrl_reg.kind == gpr_pkg::KIND_COMPUTE))
        begin
            row_mem[s2_idx_reg] <= s2_pix_reg;
        end
        if (take)
        begin
            s2_ctrl_reg <= in_ctrl;
            s2_idx_reg  <= in_idx;
            s2_pix_reg  <= in_pix;
        end
        if (s2_adv)
        begin
            out_pix_reg  <= pix_sel;
            out_last_reg <= s2_ctrl_reg.row_end;
            out_user_reg <= s2_ctrl_reg.frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            last_pix_reg  <= '0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            if (s2_adv)
            begin
                last_pix_reg <= pix_sel;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pix_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

    a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_user_reg |-> out_last_reg)
        else $error("Frame end marked on a pixel that does not end a row.");

endmodule

@@ rtl/core/gaussian_pyramid_reduce_rgb.sv @@
// ----------------------------------------------------------------------------
// gaussian_pyramid_reduce_rgb
// One Gaussian pyramid reduce step on an RGB pixel stream in raster order.
// ----------------------------------------------------------------------------
// Input pixels arrive on the s_ channel, one per transfer, in raster order.
// Reduced pixels leave on the m_ channel; tlast marks the last pixel of a
// reduced row and tuser the last pixel of the reduced frame. The reduced
// image is floor(W/2) by floor(H/2) pixels.
// A result moves through the s1 and s2 stages and the output register after
// the transfer of the input pixel that completes it. The line store is a
// simple dual-port memory read at acceptance and written back one stage
// later, so one pixel per clock is taken unless m_tready holds the output.
// Register writes on the cfg_ port set the frame width (index 0) and height
// (index 1) and restart the frame at row 0, column 0; the user must make them
// while the block is idle, which it does not enforce. Reset loads a 640 by 480
// frame and empties the pipeline; the line and row memories need no clearing.
// When the receiver holds m_tready low, the output register keeps its pixel,
// the stages behind it fill, and s_tready falls once all of them are full.
// ----------------------------------------------------------------------------
module gaussian_pyramid_reduce_rgb #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [gpr_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [gpr_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,  // pix_red, pix_green, pix_blue
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,  // out_red, out_green, out_blue
    output logic                          m_tlast,  // row_end
    output logic                          m_tuser   // frame_end
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int OW = $clog2(MAX_WIDTH / 2);

    logic               accept;
    logic [CW-1:0]      col;
    logic [OW-1:0]      idx;
    gpr_pkg::pix_ctrl_t ctrl;

    logic               s1_valid_reg, s1_valid_next;
    gpr_pkg::rgb_t      s1_pix_reg;
    logic [CW-1:0]      s1_col_reg;
    logic [OW-1:0]      s1_idx_reg;
    gpr_pkg::pix_ctrl_t s1_ctrl_reg;

    logic               s2_ready;
    logic               s1_adv;
    gpr_pkg::rgb_t      filt_pix;

    assign s1_adv   = s1_valid_reg && s2_ready;
    assign s_tready = !s1_valid_reg || s2_ready;
    assign accept   = s_tvalid && s_tready;

    gpr_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .col       (col),
        .idx       (idx),
        .ctrl      (ctrl)
    );

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else
        begin
            s1_valid_next = s1_valid_reg && !s1_adv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= gpr_pkg::rgb_t'(s_tdata);
            s1_col_reg  <= col;
            s1_idx_reg  <= idx;
            s1_ctrl_reg <= ctrl;
        end
    end

    gpr_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (col),
        .adv      (s1_adv),
        .wr_addr  (s1_col_reg),
        .cur_pix  (s1_pix_reg),
        .filt_pix (filt_pix)
    );

    gpr_out_stage #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s1_valid_reg),
        .in_ready (s2_ready),
        .in_ctrl  (s1_ctrl_reg),
        .in_idx   (s1_idx_reg),
        .in_pix   (filt_pix),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

@@ tb/sv/gpr_reduce_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gpr_reduce_checker
// Predicts every reduced RGB pixel from the accepted input stream and the
// register writes, and compares each result transfer field by field with the
// oldest pending prediction.
// ----------------------------------------------------------------------------
module gpr_reduce_checker #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [11:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // pix_red, pix_green, pix_blue
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // out_red, out_green, out_blue
    input  logic        m_tlast,   // row_end
    input  logic        m_tuser,   // frame_end
    output int          mismatch_count,
    output int          outstanding
);

    typedef struct packed {
        gpr_pkg::rgb_t pix;
        logic          row_end;
        logic          frame_end;
    } reduced_pix_t;

    logic [gpr_pkg::CFG_W-1:0] width_reg;
    logic [gpr_pkg::CFG_W-1:0] height_reg;
    gpr_pkg::line_word_t       line_mem [MAX_WIDTH];
    gpr_pkg::win_col_t         win [3];
    gpr_pkg::rgb_t             row_mem [MAX_WIDTH/2];
    gpr_pkg::rgb_t             last_pix;
    int unsigned               col_pos;
    int unsigned               row_pos;
    reduced_pix_t              reduced_q [$];

    function automatic gpr_pkg::rgb_t blur_window();
        gpr_pkg::rgb_t res;
        int            sum;
        for (int ch = 0; ch < 3; ch++)
        begin
            sum = 8;
            for (int x = 0; x < 3; x++)
                for (int y = 0; y < 3; y++)
                    sum += ((x == 1) ? 2 : 1) * ((y == 1) ? 2 : 1) * int'(win[x][y][ch]);
            res[ch] = 8'(sum >> 4);
        end
        return res;
    endfunction

    function automatic void reduce_step(input gpr_pkg::rgb_t px);
        int unsigned   w;
        int unsigned   h;
        int unsigned   r;
        int unsigned   c;
        int unsigned   idx;
        bit            even_col;
        bit            repeat_col;
        bit            emit;
        gpr_pkg::rgb_t res;
        reduced_pix_t  exp_pix;
        if (width_reg < gpr_pkg::MIN_DIM)
            w = 3;
        else
            w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        h = (height_reg < gpr_pkg::MIN_DIM) ? 3 : height_reg;
        r = row_pos;
        c = col_pos;
        even_col = (c >= 2) && (c % 2 == 0);
        repeat_col = (c == w - 1) && (w % 2 == 0);
        emit = 1'b0;
        res = '0;

        win[0] = win[1];
        win[1] = win[2];
        win[2][0] = line_mem[c][0];
        win[2][1] = line_mem[c][1];
        win[2][2] = px;
        line_mem[c][0] = line_mem[c][1];
        line_mem[c][1] = px;

        if (r >= 2 && r % 2 == 0)
        begin
            if (even_col)
            begin
                idx = ((c - 2) >> 1) % (MAX_WIDTH / 2);
                res = blur_window();
                row_mem[idx] = res;
                emit = 1'b1;
            end
            else if (repeat_col)
            begin
                res = last_pix;
                emit = 1'b1;
            end
        end
        else if (r == h - 1 && h % 2 == 0)
        begin
            if (even_col)
            begin
                idx = ((c - 2) >> 1) % (MAX_WIDTH / 2);
                res = row_mem[idx];
                emit = 1'b1;
            end
            else if (repeat_col)
            begin
                res = last_pix;
                emit = 1'b1;
            end
        end

        if (emit)
        begin
            last_pix = res;
            exp_pix.pix = res;
            exp_pix.row_end = (c == w - 1);
            exp_pix.frame_end = (c == w - 1) && (r == h - 1);
            reduced_q.push_back(exp_pix);
        end

        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
            col_pos = c + 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        reduced_pix_t  exp_pix;
        gpr_pkg::rgb_t got;
        if (!rst_n)
        begin
            width_reg = gpr_pkg::FRAME_WIDTH_RESET;
            height_reg = gpr_pkg::FRAME_HEIGHT_RESET;
            for (int i = 0; i < MAX_WIDTH; i++)
                line_mem[i] = '0;
            for (int i = 0; i < MAX_WIDTH / 2; i++)
                row_mem[i] = '0;
            for (int i = 0; i < 3; i++)
                win[i] = '0;
            last_pix = '0;
            col_pos = 0;
            row_pos = 0;
            reduced_q.delete();
            mismatch_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = gpr_pkg::rgb_t'(m_tdata);
                if (reduced_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected reduced pixel rgb %h %h %h last %b frame %b",
                                 $time, got[0], got[1], got[2], m_tlast, m_tuser);
                end
                else
                begin
                    exp_pix = reduced_q.pop_front();
                    if (got !== exp_pix.pix || m_tlast !== exp_pix.row_end ||
                        m_tuser !== exp_pix.frame_end)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"%0t: reduced pixel mismatch: expected rgb %h %h %h ",
                                      "last %b frame %b, got rgb %h %h %h last %b frame %b"},
                                     $time, exp_pix.pix[0], exp_pix.pix[1], exp_pix.pix[2],
                                     exp_pix.row_end, exp_pix.frame_end,
                                     got[0], got[1], got[2], m_tlast, m_tuser);
                    end
                end
            end

            if (cfg_wr_en && (cfg_addr == gpr_pkg::REG_FRAME_WIDTH ||
                              cfg_addr == gpr_pkg::REG_FRAME_HEIGHT))
            begin
                if (cfg_addr == gpr_pkg::REG_FRAME_WIDTH)
                    width_reg = cfg_wdata;
                else
                    height_reg = cfg_wdata;
                col_pos = 0;
                row_pos = 0;
            end

            if (s_tvalid && s_tready)
                reduce_step(gpr_pkg::rgb_t'(s_tdata));

            outstanding = reduced_q.size();
        end
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the RGB Gaussian pyramid reduce block.
// ----------------------------------------------------------------------------
// Drives short directed frames, frames with no idling, a long receiver
// hold-off, a mid-frame drain, the extreme register values and then randomly
// sized frames with random pixels, cut frames and random idling on both
// streams. A separate checker predicts and compares every reduced pixel; a
// watchdog ends the run when no transfer happens for too long.
// ----------------------------------------------------------------------------
module tb;

    localparam int MAX_WIDTH     = 2048;
    localparam int IDLE_PCT      = 28;
    localparam int RANDOM_ITEMS  = 360;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;

    typedef enum int {PIX_RANDOM, PIX_ZERO, PIX_FULL, PIX_EXTREME} pix_style_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [gpr_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
    logic [gpr_pkg::CFG_W-1:0]     cfg_wdata = '0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [23:0]                   s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [23:0]                   m_tdata;
    logic                          m_tlast;
    logic                          m_tuser;

    int mismatch_count;
    int outstanding;
    int send_idle_pct = IDLE_PCT;
    int rcv_idle_pct = IDLE_PCT;
    bit hold_req = 1'b0;
    int sent_count = 0;
    int frame_pixels = 0;
    int idle_run = 0;
    int w_eff = 640;
    int h_eff = 480;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    gaussian_pyramid_reduce_rgb #(
        .MAX_WIDTH (MAX_WIDTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    gpr_reduce_checker #(
        .MAX_WIDTH (MAX_WIDTH)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_run <= 0;
        else if (rst_n)
            idle_run <= idle_run + 1;
        if (idle_run >= STALL_LIMIT)
        begin
            $display("** gaussian_pyramid_reduce_rgb: FAILED **");
            $finish;
        end
    end

    initial
    begin : rx_side
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    function automatic gpr_pkg::rgb_t make_pixel(input pix_style_t style);
        gpr_pkg::rgb_t px;
        for (int k = 0; k < 3; k++)
            case (style)
                PIX_ZERO:    px[k] = 8'h00;
                PIX_FULL:    px[k] = 8'hff;
                PIX_EXTREME: px[k] = $urandom_range(1) ? 8'hff : 8'h00;
                default:     px[k] = ($urandom_range(15) == 0) ?
                                     ($urandom_range(1) ? 8'hff : 8'h00) : 8'($urandom);
            endcase
        return px;
    endfunction

    task automatic push_pixel(input gpr_pkg::rgb_t px);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_pixels(input int count, input pix_style_t style, input int pause_at);
        for (int i = 0; i < count; i++)
        begin
            if (i == pause_at)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (outstanding != 0)
                    @(posedge clk);
            end
            push_pixel(make_pixel(style));
            sent_count++;
        end
    endtask

    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input bit set_w, input logic [gpr_pkg::CFG_W-1:0] w_val,
                             input bit set_h, input logic [gpr_pkg::CFG_W-1:0] h_val);
        if (set_w)
        begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= gpr_pkg::REG_FRAME_WIDTH;
            cfg_wdata <= w_val;
            @(posedge clk);
            if (w_val < gpr_pkg::MIN_DIM)
                w_eff = 3;
            else
                w_eff = (w_val > MAX_WIDTH) ? MAX_WIDTH : int'(w_val);
        end
        if (set_h)
        begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= gpr_pkg::REG_FRAME_HEIGHT;
            cfg_wdata <= h_val;
            @(posedge clk);
            h_eff = (h_val < gpr_pkg::MIN_DIM) ? 3 : int'(h_val);
        end
        cfg_wr_en <= 1'b0;
        frame_pixels = w_eff * h_eff;
    endtask

    initial
    begin : stimulus
        logic [gpr_pkg::CFG_W-1:0] w_val;
        logic [gpr_pkg::CFG_W-1:0] h_val;
        logic [gpr_pkg::CFG_W-1:0] cur_w;
        logic [gpr_pkg::CFG_W-1:0] cur_h;
        int                        sel;
        int                        base_count;
        int                        nframes;
        int                        pause_at;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure(1'b1, 12'd2, 1'b1, 12'd0);
        send_pixels(frame_pixels, PIX_FULL, -1);
        quiesce();
        configure(1'b1, 12'd4, 1'b1, 12'd4);
        send_pixels(frame_pixels, PIX_EXTREME, -1);
        quiesce();

        send_idle_pct = 0;
        rcv_idle_pct = 0;
        configure(1'b1, 12'd10, 1'b1, 12'd7);
        send_pixels(2 * frame_pixels, PIX_RANDOM, -1);
        quiesce();
        send_idle_pct = IDLE_PCT;
        rcv_idle_pct = IDLE_PCT;

        configure(1'b1, 12'd24, 1'b1, 12'd6);
        hold_req = 1'b1;
        send_pixels(frame_pixels, PIX_RANDOM, -1);
        quiesce();

        configure(1'b1, 12'd9, 1'b1, 12'd8);
        send_pixels(frame_pixels, PIX_RANDOM, 4 * 9 + 5);
        quiesce();

        configure(1'b1, 12'd4095, 1'b1, 12'd3);
        send_pixels(40, PIX_RANDOM, -1);
        quiesce();
        configure(1'b1, 12'd2048, 1'b1, 12'd2);
        send_pixels(40, PIX_EXTREME, -1);
        quiesce();
        configure(1'b1, 12'd3, 1'b1, 12'd4095);
        send_pixels(45, PIX_RANDOM, -1);
        quiesce();
        configure(1'b1, 12'd4, 1'b1, 12'd2048);
        send_pixels(30, PIX_RANDOM, -1);
        quiesce();

        cur_w = 12'd4;
        cur_h = 12'd2048;
        base_count = sent_count;
        while (sent_count - base_count < RANDOM_ITEMS)
        begin
            sel = $urandom_range(99);
            w_val = (sel < 75) ? $urandom_range(3, 16) :
                    ((sel < 87) ? $urandom_range(0, 2) : $urandom_range(17, 40));
            sel = $urandom_range(99);
            h_val = (sel < 75) ? $urandom_range(3, 10) :
                    ((sel < 87) ? $urandom_range(0, 2) : $urandom_range(11, 16));
            sel = $urandom_range(9);
            if (sel == 9)
                w_val = cur_w;
            if (sel == 8 || cur_h > 16)
                h_val = (cur_h > 16) ? h_val : cur_h;
            cur_w = w_val;
            cur_h = h_val;
            configure(1'b1, w_val, 1'b1, h_val);
            if (sel == 9)
                configure(1'b0, w_val, 1'b1, h_val);
            else if (sel == 8)
                configure(1'b1, w_val, 1'b0, h_val);
            configure(1'b1, w_val, 1'b1, h_val);

            nframes = ($urandom_range(9) < 3) ? 2 : 1;
            for (int f = 0; f < nframes; f++)
            begin
                pause_at = ($urandom_range(9) == 0) ? $urandom_range(1, frame_pixels - 1) : -1;
                send_pixels(frame_pixels, PIX_RANDOM, pause_at);
            end
            if ($urandom_range(3) == 0)
                send_pixels($urandom_range(1, frame_pixels - 1), PIX_RANDOM, -1);
            quiesce();
        end

        if (mismatch_count == 0 && outstanding == 0)
            $display("** gaussian_pyramid_reduce_rgb: PASSED **");
        else
            $display("** gaussian_pyramid_reduce_rgb: FAILED **");
        $finish;
    end

endmodule
